// ===== hw/rtl/qr_format_info_decoder_core_defines.svh =====
// Assertion macros shared by the format information decoder RTL.
`ifndef QR_FORMAT_INFO_DECODER_CORE_DEFINES_SVH
`define QR_FORMAT_INFO_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define QRFI_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrfi: implication check failed");
// Next-cycle implication.
`define QRFI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrfi: next-cycle check failed");
`else
`define QRFI_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define QRFI_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/qrfi_pkg.sv =====
// Types, constants and helper functions of the format information decoder.
package qrfi_pkg;

    // Search dimensions: three mask slots times four copies, 32 codewords.
    localparam int QRFI_NUM_MASKS  = 3;
    localparam int QRFI_NUM_COPIES = 4;
    localparam int QRFI_NUM_SLOTS  = QRFI_NUM_MASKS * QRFI_NUM_COPIES;
    localparam int QRFI_NUM_CODES  = 32;
    localparam int QRFI_GROUP_SIZE = 8;
    localparam int QRFI_NUM_GROUPS = QRFI_NUM_CODES / QRFI_GROUP_SIZE;

    // Standard Model 2 mask that the codeword table below carries.
    localparam logic [14:0] CODE_MASK_STD = 15'h5412;

    // Distance code of a disabled candidate: worse than any real distance.
    localparam logic [4:0] DIST_NONE = 5'd16;

    // Register reset values.
    localparam logic [14:0] MODEL2_MASK_RST = 15'h5412;
    localparam logic [14:0] MODEL1_MASK_RST = 15'h2825;
    localparam logic [14:0] MICRO_MASK_RST  = 15'h4445;

    // Mask kind codes reported with each result.
    localparam logic [1:0] MASK_MODEL2   = 2'd0;
    localparam logic [1:0] MASK_UNMASKED = 2'd1;
    localparam logic [1:0] MASK_MODEL1   = 2'd2;
    localparam logic [1:0] MASK_MICRO    = 2'd3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SYMBOL_KIND = 2'd0,
        CFG_MODEL2_MASK = 2'd1,
        CFG_MODEL1_MASK = 2'd2,
        CFG_MICRO_MASK  = 2'd3
    } t_cfg_index;

    // BCH(15,5) codewords, stored with the standard Model 2 mask applied.
    localparam logic [14:0] MASKED_CODES [QRFI_NUM_CODES] = '{
        15'h5412, 15'h5125, 15'h5E7C, 15'h5B4B, 15'h45F9, 15'h40CE, 15'h4F97, 15'h4AA0,
        15'h77C4, 15'h72F3, 15'h7DAA, 15'h789D, 15'h662F, 15'h6318, 15'h6C41, 15'h6976,
        15'h1689, 15'h13BE, 15'h1CE7, 15'h19D0, 15'h0762, 15'h0255, 15'h0D0C, 15'h083B,
        15'h355F, 15'h3068, 15'h3F31, 15'h3A06, 15'h24B4, 15'h2183, 15'h2EDA, 15'h2BED
    };

    // Micro QR version M1..M4 selected by the three error correction bits.
    localparam logic [2:0] MICRO_VERSIONS [8] = '{
        3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
    };

    // One input item.
    typedef struct packed {
        logic [14:0] format_word_a;
        logic [15:0] format_word_b;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [4:0] format_data;
        logic [3:0] bit_distance;
        logic [1:0] mask_kind;
        logic [1:0] copy_index;
        logic       mirrored;
        logic [2:0] ec_bits;
        logic [2:0] data_mask_id;
        logic [2:0] micro_version;
    } t_out_item;

    // Best match found so far: distance, codeword index and candidate slot.
    typedef struct packed {
        logic [4:0] hamming;
        logic [4:0] code_idx;
        logic [3:0] slot;
    } t_match;

    // Unmasked codeword for a given index.
    function automatic logic [14:0] code_word(input logic [4:0] idx);
        code_word = MASKED_CODES[idx] ^ CODE_MASK_STD;
    endfunction

    // Keep the earlier match unless the later one is strictly closer.
    function automatic t_match best_of(input t_match early, input t_match late);
        best_of = (late.hamming < early.hamming) ? late : early;
    endfunction

endpackage

// ===== hw/rtl/qr_format_info_decoder_core.sv =====
// Top level of the QR format information decoder: registers, pipeline and config.
//
//  Channel   Direction  Handshake                 Payload
//  in        to core    i_in_valid / o_in_stall   i_in_item  (t_in_item)
//  out       from core  o_out_valid / i_out_stall o_out_item (t_out_item)
//  cfg       to core    i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_in_stall is low; on its way to the outputs it passes
// the input register, candidate register, group-minimum register, slot-minimum register
// and result register.
// The depth is set by the 384 popcounts and their ordered minimum tree.
// Reset is synchronous and active low; it empties the pipeline and restores the masks.
// A stalled output holds every stage that has no free slot behind it; bubbles still close up.
`include "qr_format_info_decoder_core_defines.svh"

module qr_format_info_decoder_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  qrfi_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output qrfi_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  qrfi_pkg::t_cfg_index i_cfg_index,
    input  logic [14:0]          i_cfg_data
);
    import qrfi_pkg::*;

    // Configuration registers.
    logic        r_symbol_kind;
    logic [14:0] r_model2_mask;
    logic [14:0] r_model1_mask;
    logic [14:0] r_micro_mask;

    // Pipeline registers.
    logic                                          r_v0;
    t_in_item                                      r_in;
    logic                                          r_micro0;
    logic                                          r_v1;
    logic [QRFI_NUM_SLOTS-1:0][14:0]               r_cand;
    logic [QRFI_NUM_SLOTS-1:0]                     r_cand_en;
    logic                                          r_micro1;
    logic                                          r_v2;
    t_match [QRFI_NUM_SLOTS-1:0][QRFI_NUM_GROUPS-1:0] r_grp;
    logic                                          r_micro2;
    logic                                          r_v3;
    t_match [QRFI_NUM_SLOTS-1:0]                   r_slot_best;
    logic                                          r_micro3;
    logic                                          r_out_valid;
    t_out_item                                     r_out;

    // Next values.
    logic [QRFI_NUM_SLOTS-1:0][14:0]                  n_cand;
    logic [QRFI_NUM_SLOTS-1:0]                        n_cand_en;
    t_match [QRFI_NUM_SLOTS-1:0][QRFI_NUM_GROUPS-1:0] n_grp;
    t_match [QRFI_NUM_SLOTS-1:0]                      n_slot_best;
    t_out_item                                        n_out;

    // Stage slot free signals.
    logic out_free;
    logic free3;
    logic free2;
    logic free1;
    logic free0;
    logic in_xfer;

    // A stage can load when it is empty or its content moves on this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign free3      = !r_v3 || out_free;
    assign free2      = !r_v2 || free3;
    assign free1      = !r_v1 || free2;
    assign free0      = !r_v0 || free1;
    assign o_in_stall = !free0;
    assign in_xfer    = i_in_valid && free0;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_kind <= 1'b0;
            r_model2_mask <= MODEL2_MASK_RST;
            r_model1_mask <= MODEL1_MASK_RST;
            r_micro_mask  <= MICRO_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYMBOL_KIND: r_symbol_kind <= i_cfg_data[0];
                CFG_MODEL2_MASK: r_model2_mask <= i_cfg_data;
                CFG_MODEL1_MASK: r_model1_mask <= i_cfg_data;
                CFG_MICRO_MASK:  r_micro_mask  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Candidate words for the item in the input register.
    qrfi_cand_gen u_cand_gen (
        .i_item        (r_in),
        .i_micro       (r_micro0),
        .i_model2_mask (r_model2_mask),
        .i_model1_mask (r_model1_mask),
        .i_micro_mask  (r_micro_mask),
        .o_cand        (n_cand),
        .o_cand_en     (n_cand_en)
    );

    // One codeword matcher per candidate slot.
    for (genvar s = 0; s < QRFI_NUM_SLOTS; s++) begin : g_match
        qrfi_code_match u_code_match (
            .i_cand    (r_cand[s]),
            .i_cand_en (r_cand_en[s]),
            .i_slot    (4'(s)),
            .o_grp     (n_grp[s])
        );
    end

    // Best of the four groups of each slot.
    always_comb begin
        for (int s = 0; s < QRFI_NUM_SLOTS; s++) begin
            n_slot_best[s] = best_of(best_of(r_grp[s][0], r_grp[s][1]),
                                     best_of(r_grp[s][2], r_grp[s][3]));
        end
    end

    // Best slot and field split.
    qrfi_best_select u_best_select (
        .i_slot_best (r_slot_best),
        .i_micro     (r_micro3),
        .o_item      (n_out)
    );

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (free0) begin
                r_v0 <= i_in_valid;
            end
            if (free1) begin
                r_v1 <= r_v0;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
            if (out_free) begin
                r_out_valid <= r_v3;
            end
        end
    end

    // Payload registers advance with their stage.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in     <= i_in_item;
            r_micro0 <= r_symbol_kind;
        end
        if (free1) begin
            r_cand    <= n_cand;
            r_cand_en <= n_cand_en;
            r_micro1  <= r_micro0;
        end
        if (free2) begin
            r_grp    <= n_grp;
            r_micro2 <= r_micro1;
        end
        if (free3) begin
            r_slot_best <= n_slot_best;
            r_micro3    <= r_micro2;
        end
        if (out_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Slot zero is enabled in both symbol kinds, so its best distance is always real.
    `QRFI_ASSERT_IMPLY(a_slot0_real, i_clk, i_rst_n, r_v3, r_slot_best[0].hamming[4] == 1'b0)
    // A finished item in the last stage reaches the result register when it is free.
    `QRFI_ASSERT_NEXT(a_last_stage_moves, i_clk, i_rst_n, r_v3 && out_free, o_out_valid)
    // Micro QR results always name a version.
    `QRFI_ASSERT_IMPLY(a_micro_version, i_clk, i_rst_n, o_out_valid && (o_out_item.mask_kind == MASK_MICRO), o_out_item.micro_version != 3'd0)

endmodule

// ===== hw/rtl/qrfi_cand_gen.sv =====
// Candidate word builder: copies, dark module strip, mirroring and mask XOR.
module qrfi_cand_gen (
    input  qrfi_pkg::t_in_item                             i_item,
    input  logic                                           i_micro,
    input  logic [14:0]                                    i_model2_mask,
    input  logic [14:0]                                    i_model1_mask,
    input  logic [14:0]                                    i_micro_mask,
    output logic [qrfi_pkg::QRFI_NUM_SLOTS-1:0][14:0]      o_cand,
    output logic [qrfi_pkg::QRFI_NUM_SLOTS-1:0]            o_cand_en
);
    import qrfi_pkg::*;

    logic [QRFI_NUM_COPIES-1:0][14:0] copies;
    logic [QRFI_NUM_MASKS-1:0][14:0]  masks;
    logic [14:0]                      b_strip8;
    logic [14:0]                      b_strip7;

    // Reverse the bit order of a 15-bit word.
    function automatic logic [14:0] flip15(input logic [14:0] v);
        logic [14:0] r;
        for (int i = 0; i < 15; i++) begin
            r[14 - i] = v[i];
        end
        flip15 = r;
    endfunction

    // Word b with the dark module removed, as read and in mirrored position.
    assign b_strip8 = {i_item.format_word_b[15:9], i_item.format_word_b[7:0]};
    assign b_strip7 = {i_item.format_word_b[15:8], i_item.format_word_b[6:0]};

    // The four copies in search order.
    assign copies[0] = i_item.format_word_a;
    assign copies[1] = b_strip8;
    assign copies[2] = flip15(i_item.format_word_a);
    assign copies[3] = flip15(b_strip7);

    // Mask slots; Micro QR uses only the first slot.
    assign masks[0] = i_micro ? i_micro_mask : i_model2_mask;
    assign masks[1] = '0;
    assign masks[2] = i_model1_mask;

    // Slot m * 4 + c holds copy c under mask m.
    always_comb begin
        for (int m = 0; m < QRFI_NUM_MASKS; m++) begin
            for (int c = 0; c < QRFI_NUM_COPIES; c++) begin
                o_cand[m * QRFI_NUM_COPIES + c] = copies[c] ^ masks[m];
                if (i_micro) begin
                    o_cand_en[m * QRFI_NUM_COPIES + c] = (m == 0) && (c == 0 || c == 2);
                end else begin
                    o_cand_en[m * QRFI_NUM_COPIES + c] = 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/qrfi_code_match.sv =====
// Distance of one candidate to all codewords, reduced to one best match per group.
module qrfi_code_match (
    input  logic [14:0]                                          i_cand,
    input  logic                                                 i_cand_en,
    input  logic [3:0]                                           i_slot,
    output qrfi_pkg::t_match [qrfi_pkg::QRFI_NUM_GROUPS-1:0]     o_grp
);
    import qrfi_pkg::*;

    t_match [QRFI_NUM_CODES-1:0]   all_match;
    t_match [QRFI_NUM_CODES/2-1:0] lvl1;
    t_match [QRFI_NUM_CODES/4-1:0] lvl2;

    // Hamming distance to every codeword; a disabled slot never wins.
    always_comb begin
        for (int k = 0; k < QRFI_NUM_CODES; k++) begin
            all_match[k].code_idx = 5'(k);
            all_match[k].slot     = i_slot;
            if (i_cand_en) begin
                all_match[k].hamming = {1'b0, 4'($countones(i_cand ^ code_word(5'(k))))};
            end else begin
                all_match[k].hamming = DIST_NONE;
            end
        end
    end

    // Ordered pairwise reduction inside each group of eight codewords.
    always_comb begin
        for (int i = 0; i < QRFI_NUM_CODES / 2; i++) begin
            lvl1[i] = best_of(all_match[2 * i], all_match[2 * i + 1]);
        end
        for (int i = 0; i < QRFI_NUM_CODES / 4; i++) begin
            lvl2[i] = best_of(lvl1[2 * i], lvl1[2 * i + 1]);
        end
        for (int g = 0; g < QRFI_NUM_GROUPS; g++) begin
            o_grp[g] = best_of(lvl2[2 * g], lvl2[2 * g + 1]);
        end
    end

endmodule

// ===== hw/rtl/qrfi_best_select.sv =====
// Final choice over all candidate slots and split of the winning data bits.
module qrfi_best_select (
    input  qrfi_pkg::t_match [qrfi_pkg::QRFI_NUM_SLOTS-1:0] i_slot_best,
    input  logic                                            i_micro,
    output qrfi_pkg::t_out_item                             o_item
);
    import qrfi_pkg::*;

    t_match [5:0] lvl1;
    t_match [2:0] lvl2;
    t_match       lvl3;
    t_match       winner;
    logic [14:0]  win_code;
    logic [4:0]   data;

    // Ordered tree: the earlier slot keeps a tie.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            lvl1[i] = best_of(i_slot_best[2 * i], i_slot_best[2 * i + 1]);
        end
        for (int i = 0; i < 3; i++) begin
            lvl2[i] = best_of(lvl1[2 * i], lvl1[2 * i + 1]);
        end
        lvl3   = best_of(lvl2[0], lvl2[1]);
        winner = best_of(lvl3, lvl2[2]);
    end

    assign win_code = code_word(winner.code_idx);
    assign data     = win_code[14:10];

    // Field split depends on the symbol kind.
    always_comb begin
        o_item.format_data  = data;
        o_item.bit_distance = winner.hamming[3:0];
        o_item.copy_index   = winner.slot[1:0];
        o_item.mirrored     = winner.slot[1];
        if (i_micro) begin
            o_item.mask_kind     = MASK_MICRO;
            o_item.ec_bits       = data[4:2];
            o_item.data_mask_id  = {1'b0, data[1:0]};
            o_item.micro_version = MICRO_VERSIONS[data[4:2]];
        end else begin
            o_item.mask_kind     = winner.slot[3:2];
            o_item.ec_bits       = {1'b0, data[4:3]};
            o_item.data_mask_id  = data[2:0];
            o_item.micro_version = '0;
        end
    end

endmodule

// ===== test/qr_format_info_checker.sv =====
// Checker for the format information decoder: predicts every result and compares it.
module qr_format_info_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  qrfi_pkg::t_in_item   i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  qrfi_pkg::t_out_item  i_out_item,
    input  logic                 i_cfg_we,
    input  qrfi_pkg::t_cfg_index i_cfg_index,
    input  logic [14:0]          i_cfg_data,
    output int                   o_failures,
    output int                   o_pending,
    output int                   o_results
);
    import qrfi_pkg::*;

    // Copy index codes reported with each result.
    localparam logic [1:0] COPY_A        = 2'd0;
    localparam logic [1:0] COPY_B        = 2'd1;
    localparam logic [1:0] COPY_A_MIRROR = 2'd2;
    localparam logic [1:0] COPY_B_MIRROR = 2'd3;

    // Shadow copy of the configuration registers.
    logic        symbol_is_micro;
    logic [14:0] model2_mask;
    logic [14:0] model1_mask;
    logic [14:0] micro_mask;

    // Predicted results, oldest first.
    t_out_item   expected_q[$];

    // BCH(15,5) codeword for five data bits, generator x^10+x^8+x^5+x^4+x^2+x+1.
    function automatic logic [14:0] bch_codeword(input logic [4:0] data);
        logic [14:0] rem;
        int          i;
        rem = {data, 10'd0};
        for (i = 14; i >= 10; i--) begin
            if (rem[i]) begin
                rem = rem ^ (15'h0537 << (i - 10));
            end
        end
        return {data, rem[9:0]};
    endfunction

    // Bit i moves to bit 14-i.
    function automatic logic [14:0] mirror15(input logic [14:0] w);
        logic [14:0] r;
        int          i;
        for (i = 0; i < 15; i++) begin
            r[14 - i] = w[i];
        end
        return r;
    endfunction

    // Micro QR symbol version selected by the three error correction bits.
    function automatic logic [2:0] micro_version_of(input logic [2:0] ec);
        case (ec)
            3'd0:       return 3'd1;
            3'd1, 3'd2: return 3'd2;
            3'd3, 3'd4: return 3'd3;
            default:    return 3'd4;
        endcase
    endfunction

    // Nearest codeword search in the order mask, copy, codeword; a tie keeps the earlier one.
    function automatic t_out_item predict_format(input t_in_item item);
        logic [14:0] words [4];
        logic [1:0]  copies [4];
        logic [14:0] masks [3];
        logic [1:0]  kinds [3];
        int          n_words;
        int          n_masks;
        int          m;
        int          c;
        int          k;
        logic [4:0]  cur_dist;
        logic [4:0]  best_dist;
        logic [4:0]  best_data;
        logic [1:0]  best_kind;
        logic [1:0]  best_copy;
        t_out_item   res;

        if (symbol_is_micro) begin
            words[0]  = item.format_word_a;
            copies[0] = COPY_A;
            words[1]  = mirror15(item.format_word_a);
            copies[1] = COPY_A_MIRROR;
            n_words   = 2;
            masks[0]  = micro_mask;
            kinds[0]  = MASK_MICRO;
            n_masks   = 1;
        end else begin
            // The dark module sits at bit 8 as read and at bit 7 in the mirrored copy.
            words[0]  = item.format_word_a;
            copies[0] = COPY_A;
            words[1]  = {item.format_word_b[15:9], item.format_word_b[7:0]};
            copies[1] = COPY_B;
            words[2]  = mirror15(item.format_word_a);
            copies[2] = COPY_A_MIRROR;
            words[3]  = mirror15({item.format_word_b[15:8], item.format_word_b[6:0]});
            copies[3] = COPY_B_MIRROR;
            n_words   = 4;
            masks[0]  = model2_mask;
            kinds[0]  = MASK_MODEL2;
            masks[1]  = 15'd0;
            kinds[1]  = MASK_UNMASKED;
            masks[2]  = model1_mask;
            kinds[2]  = MASK_MODEL1;
            n_masks   = 3;
        end

        best_dist = 5'd16;
        best_data = 5'd0;
        best_kind = MASK_MODEL2;
        best_copy = COPY_A;
        for (m = 0; m < n_masks; m++) begin
            for (c = 0; c < n_words; c++) begin
                for (k = 0; k < 32; k++) begin
                    cur_dist = 5'($countones(words[c] ^ masks[m] ^ bch_codeword(5'(k))));
                    if (cur_dist < best_dist) begin
                        best_dist = cur_dist;
                        best_data = 5'(k);
                        best_kind = kinds[m];
                        best_copy = copies[c];
                    end
                end
            end
        end

        res.format_data  = best_data;
        res.bit_distance = best_dist[3:0];
        res.mask_kind    = best_kind;
        res.copy_index   = best_copy;
        res.mirrored     = (best_copy == COPY_A_MIRROR) || (best_copy == COPY_B_MIRROR);
        if (symbol_is_micro) begin
            res.ec_bits       = best_data[4:2];
            res.data_mask_id  = {1'b0, best_data[1:0]};
            res.micro_version = micro_version_of(best_data[4:2]);
        end else begin
            res.ec_bits       = {1'b0, best_data[4:3]};
            res.data_mask_id  = best_data[2:0];
            res.micro_version = 3'd0;
        end
        return res;
    endfunction

    // Channel monitor: predict on input transfers, compare on output transfers.
    always @(posedge i_clk) begin : monitor
        t_out_item wanted;
        if (!i_rst_n) begin
            symbol_is_micro = 1'b0;
            model2_mask     = MODEL2_MASK_RST;
            model1_mask     = MODEL1_MASK_RST;
            micro_mask      = MICRO_MASK_RST;
            expected_q.delete();
            o_failures      = 0;
            o_results       = 0;
        end else begin
            // Predict with the settings in force before any write at this edge.
            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(predict_format(i_in_item));
            end

            // Each result transfer is matched with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    o_failures++;
                    if (o_failures <= 10) begin
                        $display("ERROR: result with nothing predicted: data=%0d dist=%0d",
                                 i_out_item.format_data, i_out_item.bit_distance);
                    end
                end else begin
                    wanted = expected_q.pop_front();
                    if (wanted.format_data   !== i_out_item.format_data   ||
                        wanted.bit_distance  !== i_out_item.bit_distance  ||
                        wanted.mask_kind     !== i_out_item.mask_kind     ||
                        wanted.copy_index    !== i_out_item.copy_index    ||
                        wanted.mirrored      !== i_out_item.mirrored      ||
                        wanted.ec_bits       !== i_out_item.ec_bits       ||
                        wanted.data_mask_id  !== i_out_item.data_mask_id  ||
                        wanted.micro_version !== i_out_item.micro_version) begin
                        o_failures++;
                        if (o_failures <= 10) begin
                            $display("ERROR: result %0d expected data=%0d dist=%0d kind=%0d %s",
                                     o_results, wanted.format_data, wanted.bit_distance,
                                     wanted.mask_kind, "");
                            $display("  expected copy=%0d mir=%0d ec=%0d dm=%0d ver=%0d",
                                     wanted.copy_index, wanted.mirrored, wanted.ec_bits,
                                     wanted.data_mask_id, wanted.micro_version);
                            $display("  got data=%0d dist=%0d kind=%0d copy=%0d mir=%0d",
                                     i_out_item.format_data, i_out_item.bit_distance,
                                     i_out_item.mask_kind, i_out_item.copy_index,
                                     i_out_item.mirrored);
                            $display("  got ec=%0d dm=%0d ver=%0d", i_out_item.ec_bits,
                                     i_out_item.data_mask_id, i_out_item.micro_version);
                        end
                    end
                end
            end

            // Track register writes.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SYMBOL_KIND: symbol_is_micro = i_cfg_data[0];
                    CFG_MODEL2_MASK: model2_mask = i_cfg_data;
                    CFG_MODEL1_MASK: model1_mask = i_cfg_data;
                    CFG_MICRO_MASK:  micro_mask = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== test/tb_qr_format_info_decoder_core.sv =====
// Testbench top for the format information decoder: stimulus, register settings and verdict.
module tb_qr_format_info_decoder_core;
    import qrfi_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_item = '0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        cfg_we = 1'b0;
    t_cfg_index  cfg_index = CFG_SYMBOL_KIND;
    logic [14:0] cfg_data = '0;

    int          failures;
    int          pending;
    int          results;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          items_sent = 0;
    int          directed_items = 0;
    int          quiet_cycles = 0;

    // Settings currently loaded, used to shape well-formed words.
    logic        cur_is_micro = 1'b0;
    logic [14:0] cur_model2 = MODEL2_MASK_RST;
    logic [14:0] cur_model1 = MODEL1_MASK_RST;
    logic [14:0] cur_micro = MICRO_MASK_RST;

    always #2 clk = ~clk;

    qr_format_info_decoder_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    qr_format_info_checker u_format_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_results   (results)
    );

    // Receiver stalls at random at the configured rate.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT - 1) begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // BCH(15,5) codeword for five data bits, used to build well-formed words.
    function automatic logic [14:0] bch_codeword(input logic [4:0] data);
        logic [14:0] rem;
        int          i;
        rem = {data, 10'd0};
        for (i = 14; i >= 10; i--) begin
            if (rem[i]) begin
                rem = rem ^ (15'h0537 << (i - 10));
            end
        end
        return {data, rem[9:0]};
    endfunction

    function automatic logic [14:0] mirror15(input logic [14:0] w);
        logic [14:0] r;
        int          i;
        for (i = 0; i < 15; i++) begin
            r[14 - i] = w[i];
        end
        return r;
    endfunction

    // One input transfer, with a random gap before it; returns at the next falling edge.
    task automatic send_pair(input logic [14:0] a, input logic [15:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{format_word_a: a, format_word_b: b};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // Drop valid and let the pipeline drain before touching the registers.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Load all four registers on consecutive cycles while the block is idle.
    task automatic apply_setting(input logic kind, input logic [14:0] m2,
                                 input logic [14:0] m1, input logic [14:0] mc);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SYMBOL_KIND;
        cfg_data  <= {14'd0, kind};
        @(negedge clk);
        cfg_index <= CFG_MODEL2_MASK;
        cfg_data  <= m2;
        @(negedge clk);
        cfg_index <= CFG_MODEL1_MASK;
        cfg_data  <= m1;
        @(negedge clk);
        cfg_index <= CFG_MICRO_MASK;
        cfg_data  <= mc;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        cur_is_micro = kind;
        cur_model2   = m2;
        cur_model1   = m1;
        cur_micro    = mc;
    endtask

    // Mostly masked codewords with a few bit errors in a random copy, the rest noise.
    task automatic random_pair(output logic [14:0] a, output logic [15:0] b);
        logic [14:0] w;
        logic [14:0] v;
        logic [14:0] mk;
        logic        use_b;
        logic        flip;
        int          errs;
        int          i;
        int          pos;
        a = 15'($urandom);
        b = 16'($urandom);
        if ($urandom_range(99) < 25) begin
            return;
        end
        if (cur_is_micro) begin
            mk = cur_micro;
        end else begin
            case ($urandom_range(2))
                0:       mk = cur_model2;
                1:       mk = 15'd0;
                default: mk = cur_model1;
            endcase
        end
        w = bch_codeword(5'($urandom_range(31))) ^ mk;
        errs = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(2);
        for (i = 0; i < errs; i++) begin
            pos = $urandom_range(14);
            w[pos] = ~w[pos];
        end
        use_b = cur_is_micro ? 1'b0 : 1'($urandom_range(1));
        flip  = 1'($urandom_range(1));
        if (!use_b) begin
            a = flip ? mirror15(w) : w;
        end else if (!flip) begin
            b = {w[14:8], b[8], w[7:0]};
        end else begin
            v = mirror15(w);
            b = {v[14:7], b[7], v[6:0]};
        end
    endtask

    // Main sequence: reset, directed cases, then random phases over several settings.
    initial begin : stimulus
        logic [14:0] w;
        logic [14:0] v;
        logic [14:0] shared;
        logic [14:0] ra;
        logic [15:0] rb;
        int          i;
        int          phase;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Field extremes and each copy and mask kind under the reset settings.
        send_pair(15'h0000, 16'h0000);
        send_pair(15'h7FFF, 16'hFFFF);
        send_pair(bch_codeword(5'd5) ^ MODEL2_MASK_RST, 16'h0000);
        send_pair(bch_codeword(5'd10), 16'h5A5A);
        send_pair(bch_codeword(5'd20) ^ MODEL1_MASK_RST, 16'hA5A5);
        w = bch_codeword(5'd7) ^ MODEL2_MASK_RST;
        send_pair(15'h2AAA, {w[14:8], 1'b1, w[7:0]});
        send_pair(mirror15(bch_codeword(5'd3) ^ MODEL2_MASK_RST), 16'h0F0F);
        v = mirror15(bch_codeword(5'd31) ^ MODEL1_MASK_RST);
        send_pair(15'h5555, {v[14:7], 1'b1, v[6:0]});
        // Both copies hold the same word: the first copy wins the tie.
        w = bch_codeword(5'd12) ^ MODEL2_MASK_RST;
        send_pair(w, {w[14:8], 1'b0, w[7:0]});
        send_pair(w ^ 15'h0111, 16'hFFFF);
        send_pair(15'h4000, 16'h8000);

        // Micro QR: every error correction code, a mirrored copy, and word b ignored.
        apply_setting(1'b1, MODEL2_MASK_RST, MODEL1_MASK_RST, MICRO_MASK_RST);
        for (i = 0; i < 8; i++) begin
            send_pair(bch_codeword(5'(i * 4 + i % 4)) ^ MICRO_MASK_RST, 16'hFFFF);
        end
        send_pair(mirror15(bch_codeword(5'd13) ^ MICRO_MASK_RST), 16'h0000);
        send_pair(15'h7FFF, 16'h0000);

        // Equal masks: the first mask in search order is reported.
        apply_setting(1'b0, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        send_pair(bch_codeword(5'd9) ^ 15'h7FFF, 16'h0000);
        send_pair(15'h0000, 16'hFFFF);
        directed_items = items_sent;

        // Random phases, each with a register setting of its own and one of four idling modes.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            shared = 15'($urandom);
            case (phase)
                0: apply_setting(1'b0, MODEL2_MASK_RST, MODEL1_MASK_RST, MICRO_MASK_RST);
                1: apply_setting(1'b1, MODEL2_MASK_RST, MODEL1_MASK_RST, MICRO_MASK_RST);
                2: apply_setting(1'b0, 15'h0000, 15'h0000, 15'h7FFF);
                3: apply_setting(1'b1, 15'h7FFF, 15'h0000, 15'h0000);
                4: apply_setting(1'b0, 15'h7FFF, 15'h7FFF, 15'h0000);
                5: apply_setting(1'b0, 15'($urandom), 15'($urandom), 15'($urandom));
                6: apply_setting(1'b1, 15'($urandom), 15'($urandom), 15'($urandom));
                default: apply_setting(1'b0, shared, shared, 15'($urandom));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 56; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 56; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                random_pair(ra, rb);
                send_pair(ra, rb);
            end
        end

        wait_idle();
        $display("Sent %0d format word pairs (%0d directed) over QR and Micro QR settings,",
                 items_sent, directed_items);
        $display("including extreme and equal masks, under four idling modes; %0d results.",
                 results);
        if (failures == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/qrfi_pkg.sv
hw/rtl/qrfi_cand_gen.sv
hw/rtl/qrfi_code_match.sv
hw/rtl/qrfi_best_select.sv
hw/rtl/qr_format_info_decoder_core.sv
test/qr_format_info_checker.sv
test/tb_qr_format_info_decoder_core.sv
